// ----- hw/rtl/qga_pkg.sv -----
// Shared types, constants and codes of the stream QoS group arbiter.
package qga_pkg;

  localparam int DEVICE_SLOTS = 8;
  localparam int GROUP_DEPTH  = 16;

  localparam int SLOT_W    = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam int IDX_W     = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int CNT_W     = $clog2(GROUP_DEPTH + 1);
  localparam int MEM_DEPTH = DEVICE_SLOTS * GROUP_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int ADDR_W = 48;
  localparam int QOS_W  = 4;
  localparam int CFG_W  = 44;
  localparam int MASK_W = 11;

  localparam logic [QOS_W-1:0] QOS_2    = 4'd2;
  localparam logic [QOS_W-1:0] QOS_3    = 4'd3;
  localparam logic [QOS_W-1:0] QOS_4    = 4'd4;
  localparam logic [QOS_W-1:0] QOS_8    = 4'd8;
  localparam logic [QOS_W-1:0] QOS_10   = 4'd10;
  localparam logic [QOS_W-1:0] QOS_BUTT = 4'd11;

  localparam logic [CFG_W-1:0]  PRIORITY_RESET = 44'd3513639916304;
  localparam logic [MASK_W-1:0] IMM_RESET      = 11'd96;
  localparam logic [MASK_W-1:0] UP_RESET       = 11'd616;
  localparam logic [MASK_W-1:0] DOWN_RESET     = 11'd2014;

  typedef enum logic [1:0] {
    REG_PRIORITY = 2'd0,
    REG_IMM_STOP = 2'd1,
    REG_UPLINK   = 2'd2,
    REG_DOWNLINK = 2'd3
  } qga_reg_t;

  typedef enum logic [2:0] {
    CMD_ADD          = 3'd0,
    CMD_DELETE       = 3'd1,
    CMD_CLEAR        = 3'd2,
    CMD_CLEAR_FAILED = 3'd3,
    CMD_SET          = 3'd4,
    CMD_SYNC         = 3'd5,
    CMD_QUERY        = 3'd6
  } qga_cmdcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_NO_SLOT    = 3'd2,
    ST_LIST_EMPTY = 3'd3,
    ST_LIST_FULL  = 3'd4,
    ST_TABLE_FULL = 3'd5
  } qga_status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SELECT,
    OP_TAKE,
    OP_APPEND,
    OP_PASS,
    OP_COPY,
    OP_CLEAR,
    OP_CLR_EMPTY,
    OP_SET_CUR,
    OP_ADD_RULE,
    OP_DEL_RULE,
    OP_RESULT
  } qga_op_t;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_Q,
    TGT_4,
    TGT_8,
    TGT_10
  } qga_tgt_t;

  typedef struct packed {
    qga_op_t     op;
    qga_tgt_t    tgt;
    qga_status_t status;
  } qga_ctl_t;

  typedef struct packed {
    logic peer_found;
    logic free_avail;
    logic has_slot;
    logic q_invalid;
    logic cnt_zero;
    logic cnt_full;
    logic peer_cnt_zero;
    logic sync_over;
    logic pass_done;
    logic drop4;
    logic drop8;
    logic drop10;
  } qga_stat_t;

endpackage

// ----- hw/rtl/stream_qos_group_arbiter.sv -----
// Top level of the stream QoS group arbiter: controller and datapath.
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | command word, s_tdata[103:0]
//  m_*      | out       | m_tvalid/m_tready  | result word,  m_tdata[15:0]
//  cfg_*    | in        | cfg_we             | cfg_index, cfg_data[43:0]
//
// One command word at a time; a word takes one walk of the list for most commands, up to
// four walks for a delete, five for a clear after a failed start and two for a sync. The
// single read port of the group memory sets how long a word takes.
// Reset is synchronous and needs no clearing pass. A new word is taken while an
// earlier result still waits in the output register; the word stalls only at its end.
module stream_qos_group_arbiter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // cmd[2:0], device_addr[50:3], qos_code[54:51], peer_addr[102:55], zero pad
  input  logic [103:0]               s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // changed[0], stop_stream[1], stop_now[2], current_qos[6:3], uplink_present[7],
  // single_down_present[8], code_present[9], status[12:10], zero pad
  output logic [15:0]                m_tdata,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [qga_pkg::CFG_W-1:0]  cfg_data
);

  qga_pkg::qga_ctl_t  ctl;
  qga_pkg::qga_stat_t stat;

  logic                      changed, stop_stream, stop_now;
  logic [qga_pkg::QOS_W-1:0] current_qos;
  logic                      uplink_present, single_down_present, code_present;
  logic [2:0]                status;

  qga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (s_tdata[2:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl),
    .stat     (stat)
  );

  qga_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .device_addr         (s_tdata[50:3]),
    .qos_code            (s_tdata[54:51]),
    .peer_addr           (s_tdata[102:55]),
    .ctl                 (ctl),
    .stat                (stat),
    .changed             (changed),
    .stop_stream         (stop_stream),
    .stop_now            (stop_now),
    .current_qos         (current_qos),
    .uplink_present      (uplink_present),
    .single_down_present (single_down_present),
    .code_present        (code_present),
    .status              (status)
  );

  assign m_tdata = {3'b000, status, code_present, single_down_present, uplink_present,
                    current_qos, stop_now, stop_stream, changed};

endmodule

// ----- hw/rtl/qga_datapath.sv -----
// Datapath: configuration, slot table, group memory, list walker and update rules.
module qga_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [qga_pkg::CFG_W-1:0]     cfg_data,
  input  logic [qga_pkg::ADDR_W-1:0]    device_addr,
  input  logic [qga_pkg::QOS_W-1:0]     qos_code,
  input  logic [qga_pkg::ADDR_W-1:0]    peer_addr,
  input  qga_pkg::qga_ctl_t             ctl,
  output qga_pkg::qga_stat_t            stat,
  output logic                          changed,
  output logic                          stop_stream,
  output logic                          stop_now,
  output logic [qga_pkg::QOS_W-1:0]     current_qos,
  output logic                          uplink_present,
  output logic                          single_down_present,
  output logic                          code_present,
  output logic [2:0]                    status
);

  localparam int SLOT_W = qga_pkg::SLOT_W;
  localparam int IDX_W  = qga_pkg::IDX_W;
  localparam int CNT_W  = qga_pkg::CNT_W;
  localparam int MEM_AW = qga_pkg::MEM_AW;
  localparam int QW     = qga_pkg::QOS_W;

  function automatic logic [3:0] prio(input logic [qga_pkg::CFG_W-1:0] tbl,
                                      input logic [QW-1:0] c);
    logic [3:0] p;
    p = 4'd0;
    if (c < qga_pkg::QOS_BUTT) p = tbl[4*c +: 4];
    return p;
  endfunction

  function automatic logic mbit(input logic [qga_pkg::MASK_W-1:0] m,
                                input logic [QW-1:0] c);
    logic b;
    b = 1'b0;
    if (c < qga_pkg::QOS_BUTT) b = m[c];
    return b;
  endfunction

  function automatic logic [MEM_AW-1:0] maddr(input logic [SLOT_W-1:0] s,
                                              input logic [IDX_W-1:0] i);
    logic [MEM_AW-1:0] a;
    a = MEM_AW'(s) * MEM_AW'(qga_pkg::GROUP_DEPTH) + MEM_AW'(i);
    return a;
  endfunction

  // Configuration registers.
  logic [qga_pkg::CFG_W-1:0]  prio_tbl;
  logic [qga_pkg::MASK_W-1:0] imm_mask;
  logic [qga_pkg::MASK_W-1:0] up_mask;
  logic [qga_pkg::MASK_W-1:0] down_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      prio_tbl  <= qga_pkg::PRIORITY_RESET;
      imm_mask  <= qga_pkg::IMM_RESET;
      up_mask   <= qga_pkg::UP_RESET;
      down_mask <= qga_pkg::DOWN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qga_pkg::REG_PRIORITY: prio_tbl  <= cfg_data;
        qga_pkg::REG_IMM_STOP: imm_mask  <= cfg_data[qga_pkg::MASK_W-1:0];
        qga_pkg::REG_UPLINK:   up_mask   <= cfg_data[qga_pkg::MASK_W-1:0];
        qga_pkg::REG_DOWNLINK: down_mask <= cfg_data[qga_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched word fields.
  logic [qga_pkg::ADDR_W-1:0] dev_l;
  logic [qga_pkg::ADDR_W-1:0] peer_l;
  logic [QW-1:0]              q_l;

  // Slot table.
  logic                       slot_valid [qga_pkg::DEVICE_SLOTS];
  logic [qga_pkg::ADDR_W-1:0] slot_addr  [qga_pkg::DEVICE_SLOTS];
  logic [QW-1:0]              slot_cur   [qga_pkg::DEVICE_SLOTS];
  logic [CNT_W-1:0]           slot_cnt   [qga_pkg::DEVICE_SLOTS];

  logic [SLOT_W-1:0] sel;
  logic [SLOT_W-1:0] peer;
  logic              has_slot;

  // Lookup, registered every cycle.
  logic              lk_dev_found, lk_peer_found, lk_free_avail;
  logic [SLOT_W-1:0] lk_dev_idx, lk_peer_idx, lk_free_idx;
  logic              lk_dev_found_c, lk_peer_found_c, lk_free_avail_c;
  logic [SLOT_W-1:0] lk_dev_idx_c, lk_peer_idx_c, lk_free_idx_c;

  always_comb begin
    lk_dev_found_c  = 1'b0;
    lk_peer_found_c = 1'b0;
    lk_free_avail_c = 1'b0;
    lk_dev_idx_c    = '0;
    lk_peer_idx_c   = '0;
    lk_free_idx_c   = '0;
    for (int i = qga_pkg::DEVICE_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_addr[i] == dev_l) begin
        lk_dev_found_c = 1'b1;
        lk_dev_idx_c   = SLOT_W'(i);
      end
      if (slot_valid[i] && slot_addr[i] == peer_l) begin
        lk_peer_found_c = 1'b1;
        lk_peer_idx_c   = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        lk_free_avail_c = 1'b1;
        lk_free_idx_c   = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    lk_dev_found  <= lk_dev_found_c;
    lk_peer_found <= lk_peer_found_c;
    lk_free_avail <= lk_free_avail_c;
    lk_dev_idx    <= lk_dev_idx_c;
    lk_peer_idx   <= lk_peer_idx_c;
    lk_free_idx   <= lk_free_idx_c;
  end

  // List walker state.
  logic             pass_active, copy_mode, rd_pend, found, pass_done, tgt_en;
  logic [CNT_W-1:0] ridx, rd_idx, len;
  logic [QW-1:0]    tgt_code;

  // Aggregates over the list as it stands after the walk.
  logic          a_has2, a_has3, a_has4, a_has8, a_has10, a_hasq;
  logic          a_up, a_sd, a_low4, a_low8, a_low10;
  logic [3:0]    a_best;
  logic [QW-1:0] a_nos;

  // Group memory.
  logic [QW-1:0]     mem [qga_pkg::MEM_DEPTH];
  logic [QW-1:0]     mem_q;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [QW-1:0]     mem_wd;

  logic [CNT_W-1:0] cnt_sel, cnt_peer, src_idx, dst_idx, shift_idx;
  logic [QW-1:0]    cur_sel, e;
  logic [3:0]       pe;
  logic             skip, pass_end;

  assign cnt_sel   = slot_cnt[sel];
  assign cnt_peer  = slot_cnt[peer];
  assign cur_sel   = slot_cur[sel];
  assign e         = mem_q;
  assign pe        = prio(prio_tbl, e);
  assign src_idx   = len - CNT_W'(1) - ridx;
  assign dst_idx   = cnt_sel + rd_idx;
  assign shift_idx = rd_idx - CNT_W'(1);
  assign skip      = tgt_en && !found && (e == tgt_code);
  assign pass_end  = pass_active && (ridx == len) && !rd_pend;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = maddr(sel, cnt_sel[IDX_W-1:0]);
    mem_wd = q_l;
    if (ctl.op == qga_pkg::OP_APPEND) begin
      mem_we = 1'b1;
    end else if (pass_active && rd_pend && copy_mode) begin
      mem_we = 1'b1;
      mem_wa = maddr(sel, dst_idx[IDX_W-1:0]);
      mem_wd = e;
    end else if (pass_active && rd_pend && found) begin
      // Entries after the removed one move down by one place.
      mem_we = 1'b1;
      mem_wa = maddr(sel, shift_idx[IDX_W-1:0]);
      mem_wd = e;
    end
    if (copy_mode) mem_ra = maddr(peer, src_idx[IDX_W-1:0]);
    else           mem_ra = maddr(sel, ridx[IDX_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_active <= 1'b0;
      rd_pend     <= 1'b0;
      pass_done   <= 1'b0;
      copy_mode   <= 1'b0;
    end else begin
      pass_done <= pass_end;
      if (ctl.op == qga_pkg::OP_PASS || ctl.op == qga_pkg::OP_COPY) begin
        pass_active <= 1'b1;
        copy_mode   <= (ctl.op == qga_pkg::OP_COPY);
        ridx        <= '0;
        rd_pend     <= 1'b0;
        found       <= 1'b0;
        len         <= (ctl.op == qga_pkg::OP_COPY) ? cnt_peer : cnt_sel;
        tgt_en      <= (ctl.tgt != qga_pkg::TGT_NONE);
        unique case (ctl.tgt)
          qga_pkg::TGT_Q:  tgt_code <= q_l;
          qga_pkg::TGT_4:  tgt_code <= qga_pkg::QOS_4;
          qga_pkg::TGT_8:  tgt_code <= qga_pkg::QOS_8;
          qga_pkg::TGT_10: tgt_code <= qga_pkg::QOS_10;
          default:         tgt_code <= '0;
        endcase
        a_has2 <= 1'b0; a_has3 <= 1'b0; a_has4 <= 1'b0; a_has8 <= 1'b0;
        a_has10 <= 1'b0; a_hasq <= 1'b0; a_up <= 1'b0; a_sd <= 1'b0;
        a_low4 <= 1'b0; a_low8 <= 1'b0; a_low10 <= 1'b0;
        a_best <= '0; a_nos <= '0;
      end else if (pass_active) begin
        if (ridx < len) begin
          ridx    <= ridx + CNT_W'(1);
          rd_idx  <= ridx;
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
        end
        if (rd_pend && !copy_mode) begin
          if (skip) begin
            found <= 1'b1;
          end else begin
            if (e == qga_pkg::QOS_2)  a_has2  <= 1'b1;
            if (e == qga_pkg::QOS_3)  a_has3  <= 1'b1;
            if (e == qga_pkg::QOS_4)  a_has4  <= 1'b1;
            if (e == qga_pkg::QOS_8)  a_has8  <= 1'b1;
            if (e == qga_pkg::QOS_10) a_has10 <= 1'b1;
            if (e == q_l)             a_hasq  <= 1'b1;
            if (mbit(up_mask, e)) a_up <= 1'b1;
            if (!mbit(up_mask, e) && mbit(down_mask, e)) a_sd <= 1'b1;
            if (pe < prio(prio_tbl, qga_pkg::QOS_4))  a_low4  <= 1'b1;
            if (pe < prio(prio_tbl, qga_pkg::QOS_8))  a_low8  <= 1'b1;
            if (pe < prio(prio_tbl, qga_pkg::QOS_10)) a_low10 <= 1'b1;
            if (pe > a_best) begin
              a_best <= pe;
              a_nos  <= e;
            end
          end
        end
        if (pass_end) begin
          pass_active <= 1'b0;
        end
      end
    end
  end

  // Add and delete choices of the next QoS.
  logic [QW-1:0] nos_d;
  logic          add_swap2, add_up, add_tie, add_lost3, del_down;

  always_comb begin
    if (cur_sel == qga_pkg::QOS_3 && a_up)      nos_d = qga_pkg::QOS_3;
    else if (cur_sel == qga_pkg::QOS_2 && a_sd) nos_d = qga_pkg::QOS_2;
    else                                        nos_d = a_nos;
    add_swap2 = (cur_sel == qga_pkg::QOS_2) && (a_nos == qga_pkg::QOS_4) && !a_has2;
    add_up    = prio(prio_tbl, cur_sel) < prio(prio_tbl, a_nos);
    add_tie   = (prio(prio_tbl, cur_sel) == prio(prio_tbl, a_nos)) &&
                (((cur_sel == qga_pkg::QOS_4) && (a_nos == qga_pkg::QOS_8)) ||
                 ((cur_sel == qga_pkg::QOS_8) && (a_nos == qga_pkg::QOS_4)));
    add_lost3 = (cur_sel == qga_pkg::QOS_3) && (q_l != qga_pkg::QOS_3) && !a_has3;
    del_down  = (prio(prio_tbl, cur_sel) > prio(prio_tbl, nos_d)) && (nos_d != '0);
  end

  logic flag_chg, flag_stop, flag_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < qga_pkg::DEVICE_SLOTS; i++) slot_valid[i] <= 1'b0;
      has_slot <= 1'b0;
      sel      <= '0;
      peer     <= '0;
    end else begin
      unique case (ctl.op)
        qga_pkg::OP_LOAD: begin
          dev_l     <= device_addr;
          peer_l    <= peer_addr;
          q_l       <= qos_code;
          flag_chg  <= 1'b0;
          flag_stop <= 1'b0;
          flag_now  <= 1'b0;
        end
        qga_pkg::OP_SELECT: begin
          sel      <= lk_dev_idx;
          peer     <= lk_peer_idx;
          has_slot <= lk_dev_found;
        end
        qga_pkg::OP_TAKE: begin
          slot_valid[lk_free_idx] <= 1'b1;
          slot_addr[lk_free_idx]  <= dev_l;
          slot_cur[lk_free_idx]   <= '0;
          slot_cnt[lk_free_idx]   <= '0;
          sel      <= lk_free_idx;
          has_slot <= 1'b1;
        end
        qga_pkg::OP_APPEND: slot_cnt[sel] <= cnt_sel + CNT_W'(1);
        qga_pkg::OP_CLEAR: begin
          slot_cur[sel] <= '0;
          slot_cnt[sel] <= '0;
        end
        qga_pkg::OP_CLR_EMPTY: begin
          if (cnt_sel == '0) slot_cur[sel] <= '0;
          flag_chg  <= 1'b0;
          flag_stop <= 1'b0;
          flag_now  <= 1'b0;
        end
        qga_pkg::OP_SET_CUR: slot_cur[sel] <= q_l;
        qga_pkg::OP_ADD_RULE: begin
          if (add_swap2 || add_up) begin
            slot_cur[sel] <= a_nos;
            flag_chg      <= 1'b1;
          end else if (add_tie) begin
            flag_chg <= 1'b1;
          end else if (add_lost3) begin
            slot_cur[sel] <= a_nos;
            flag_chg      <= 1'b1;
          end
        end
        qga_pkg::OP_DEL_RULE: begin
          if (nos_d == '0) begin
            flag_stop <= 1'b1;
            flag_now  <= mbit(imm_mask, cur_sel);
          end
          if (del_down) begin
            slot_cur[sel] <= nos_d;
            flag_chg      <= 1'b1;
          end else if (cur_sel == qga_pkg::QOS_10) begin
            slot_cur[sel] <= nos_d;
          end
        end
        qga_pkg::OP_RESULT: begin
          changed             <= flag_chg;
          stop_stream         <= flag_stop;
          stop_now            <= flag_now;
          current_qos         <= has_slot ? cur_sel : '0;
          uplink_present      <= has_slot && a_up;
          single_down_present <= has_slot && a_sd;
          code_present        <= has_slot && a_hasq;
          status              <= ctl.status;
        end
        default: ;
      endcase
      if (pass_end) begin
        if (copy_mode) begin
          slot_cnt[sel] <= cnt_sel + len;
          slot_cur[sel] <= slot_cur[peer];
        end else if (found) begin
          slot_cnt[sel] <= cnt_sel - CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    stat.peer_found    = lk_peer_found;
    stat.free_avail    = lk_free_avail;
    stat.has_slot      = has_slot;
    stat.q_invalid     = (q_l >= qga_pkg::QOS_BUTT);
    stat.cnt_zero      = (cnt_sel == '0);
    stat.cnt_full      = (cnt_sel >= CNT_W'(qga_pkg::GROUP_DEPTH));
    stat.peer_cnt_zero = (cnt_peer == '0);
    stat.sync_over     = ({1'b0, cnt_sel} + {1'b0, cnt_peer}) >
                         (CNT_W + 1)'(qga_pkg::GROUP_DEPTH);
    stat.pass_done     = pass_done;
    stat.drop4         = a_has4 && !a_low4;
    stat.drop8         = a_has8 && !a_low8;
    stat.drop10        = a_has10 && !a_low10 && (q_l != qga_pkg::QOS_10) &&
                         (q_l != qga_pkg::QOS_3);
  end

endmodule

// ----- hw/rtl/qga_ctrl.sv -----
// Controller: sequences lookup, list walks and update rules for each command word.
module qga_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [2:0]           cmd,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output qga_pkg::qga_ctl_t    ctl,
  input  qga_pkg::qga_stat_t   stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOOKUP, S_SELECT, S_DECIDE,
    S_ADD_APPEND, S_ADD_SCAN, S_ADD_WAIT,
    S_DEL_Q_WAIT, S_DEL_4, S_DEL_4_WAIT, S_DEL_8, S_DEL_8_WAIT,
    S_DEL_10, S_DEL_10_WAIT, S_DEL_RULE, S_CLR_EMPTY,
    S_COPY_WAIT, S_REPORT, S_REPORT_WAIT, S_FINISH
  } state_t;

  state_t               state, state_next;
  qga_pkg::qga_status_t st_r, st_next;
  logic [2:0]           cmd_r;
  logic                 out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    st_next    = st_r;
    ctl.op     = qga_pkg::OP_NONE;
    ctl.tgt    = qga_pkg::TGT_NONE;
    ctl.status = st_r;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.op     = qga_pkg::OP_LOAD;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: state_next = S_SELECT;
      S_SELECT: begin
        ctl.op     = qga_pkg::OP_SELECT;
        st_next    = qga_pkg::ST_OK;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (cmd_r)
          qga_pkg::CMD_ADD: begin
            if (stat.q_invalid) begin
              st_next = qga_pkg::ST_INVALID; state_next = S_REPORT;
            end else if (stat.has_slot) begin
              if (stat.cnt_full) begin
                st_next = qga_pkg::ST_LIST_FULL; state_next = S_REPORT;
              end else begin
                state_next = S_ADD_APPEND;
              end
            end else if (stat.free_avail) begin
              ctl.op = qga_pkg::OP_TAKE; state_next = S_ADD_APPEND;
            end else begin
              st_next = qga_pkg::ST_TABLE_FULL; state_next = S_FINISH;
            end
          end
          qga_pkg::CMD_DELETE: begin
            if (stat.q_invalid) begin
              st_next = qga_pkg::ST_INVALID; state_next = S_REPORT;
            end else if (!stat.has_slot) begin
              st_next = qga_pkg::ST_NO_SLOT; state_next = S_FINISH;
            end else if (stat.cnt_zero) begin
              st_next = qga_pkg::ST_LIST_EMPTY; state_next = S_REPORT;
            end else begin
              ctl.op = qga_pkg::OP_PASS; ctl.tgt = qga_pkg::TGT_Q;
              state_next = S_DEL_Q_WAIT;
            end
          end
          qga_pkg::CMD_CLEAR_FAILED: begin
            if (!stat.has_slot) begin
              st_next = qga_pkg::ST_NO_SLOT; state_next = S_FINISH;
            end else if (stat.q_invalid) begin
              st_next = qga_pkg::ST_INVALID; state_next = S_CLR_EMPTY;
            end else if (stat.cnt_zero) begin
              state_next = S_CLR_EMPTY;
            end else begin
              ctl.op = qga_pkg::OP_PASS; ctl.tgt = qga_pkg::TGT_Q;
              state_next = S_DEL_Q_WAIT;
            end
          end
          qga_pkg::CMD_CLEAR: begin
            if (!stat.has_slot) begin
              st_next = qga_pkg::ST_NO_SLOT; state_next = S_FINISH;
            end else begin
              ctl.op = qga_pkg::OP_CLEAR; state_next = S_REPORT;
            end
          end
          qga_pkg::CMD_SET: begin
            if (!stat.has_slot) begin
              st_next = qga_pkg::ST_NO_SLOT; state_next = S_FINISH;
            end else if (stat.q_invalid) begin
              st_next = qga_pkg::ST_INVALID; state_next = S_REPORT;
            end else begin
              ctl.op = qga_pkg::OP_SET_CUR; state_next = S_REPORT;
            end
          end
          qga_pkg::CMD_SYNC: begin
            if (!stat.peer_found) begin
              st_next = qga_pkg::ST_NO_SLOT; state_next = S_REPORT;
            end else if (stat.peer_cnt_zero) begin
              st_next = qga_pkg::ST_LIST_EMPTY; state_next = S_REPORT;
            end else if (stat.has_slot && stat.sync_over) begin
              st_next = qga_pkg::ST_LIST_FULL; state_next = S_REPORT;
            end else if (stat.has_slot) begin
              ctl.op = qga_pkg::OP_COPY; state_next = S_COPY_WAIT;
            end else if (stat.free_avail) begin
              // The new slot is taken now; the copy starts next cycle.
              ctl.op = qga_pkg::OP_TAKE; state_next = S_DEL_RULE;
            end else begin
              st_next = qga_pkg::ST_TABLE_FULL; state_next = S_FINISH;
            end
          end
          default: begin
            if (!stat.has_slot) st_next = qga_pkg::ST_NO_SLOT;
            state_next = S_REPORT;
          end
        endcase
      end
      S_ADD_APPEND: begin
        ctl.op = qga_pkg::OP_APPEND; state_next = S_ADD_SCAN;
      end
      S_ADD_SCAN: begin
        ctl.op = qga_pkg::OP_PASS; state_next = S_ADD_WAIT;
      end
      S_ADD_WAIT: begin
        if (stat.pass_done) begin
          ctl.op = qga_pkg::OP_ADD_RULE; state_next = S_FINISH;
        end
      end
      S_DEL_Q_WAIT: if (stat.pass_done) state_next = S_DEL_4;
      S_DEL_4: begin
        if (stat.drop4) begin
          ctl.op = qga_pkg::OP_PASS; ctl.tgt = qga_pkg::TGT_4;
          state_next = S_DEL_4_WAIT;
        end else begin
          state_next = S_DEL_8;
        end
      end
      S_DEL_4_WAIT: if (stat.pass_done) state_next = S_DEL_8;
      S_DEL_8: begin
        if (stat.drop8) begin
          ctl.op = qga_pkg::OP_PASS; ctl.tgt = qga_pkg::TGT_8;
          state_next = S_DEL_8_WAIT;
        end else begin
          state_next = S_DEL_10;
        end
      end
      S_DEL_8_WAIT: if (stat.pass_done) state_next = S_DEL_10;
      S_DEL_10: begin
        if (stat.drop10) begin
          ctl.op = qga_pkg::OP_PASS; ctl.tgt = qga_pkg::TGT_10;
          state_next = S_DEL_10_WAIT;
        end else begin
          state_next = S_DEL_RULE;
        end
      end
      S_DEL_10_WAIT: if (stat.pass_done) state_next = S_DEL_RULE;
      S_DEL_RULE: begin
        if (cmd_r == qga_pkg::CMD_SYNC) begin
          ctl.op = qga_pkg::OP_COPY; state_next = S_COPY_WAIT;
        end else begin
          ctl.op = qga_pkg::OP_DEL_RULE;
          state_next = (cmd_r == qga_pkg::CMD_CLEAR_FAILED) ? S_CLR_EMPTY : S_FINISH;
        end
      end
      S_CLR_EMPTY: begin
        ctl.op = qga_pkg::OP_CLR_EMPTY; state_next = S_REPORT;
      end
      S_COPY_WAIT: if (stat.pass_done) state_next = S_REPORT;
      S_REPORT: begin
        if (stat.has_slot) begin
          ctl.op = qga_pkg::OP_PASS; state_next = S_REPORT_WAIT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_REPORT_WAIT: if (stat.pass_done) state_next = S_FINISH;
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          ctl.op = qga_pkg::OP_RESULT; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      st_r      <= qga_pkg::ST_OK;
      out_valid <= 1'b0;
      cmd_r     <= '0;
    end else begin
      state <= state_next;
      st_r  <= st_next;
      if (state == S_IDLE && s_tvalid) cmd_r <= cmd;
      out_valid <= (state == S_FINISH && (!out_valid || m_tready)) ||
                   (out_valid && !m_tready);
    end
  end

endmodule

// ----- hw/rtl/qga_checker.sv -----
// Port-level checks of the stream QoS group arbiter and their binding.
module qga_port_checks (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [15:0]  m_tdata
);

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result offered straight after reset");

  // One word at a time: an accepted word closes the input.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still open after a word was taken");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // With the table full no slot was taken, so there is nothing to report but the status.
  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[12:10] == qga_pkg::ST_TABLE_FULL))
      |-> (m_tdata[9:0] == 10'd0))
    else $error("slot fields set without a slot");

  // An immediate stop only comes with a stop and an OK status.
  a_stop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[1] && m_tdata[12:10] == qga_pkg::ST_OK))
    else $error("immediate stop without stop");

endmodule

bind stream_qos_group_arbiter qga_port_checks u_qga_port_checks (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- bench/qga_checker.sv -----
// Checker for the stream QoS group arbiter: slot table predictor and result comparison.
`timescale 1ns / 1ps

module qga_checker
  import qga_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [103:0]        s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [15:0]         m_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output int                  errors,
  output int                  pending
);

  typedef struct {
    bit          changed;
    bit          stop_stream;
    bit          stop_now;
    bit [3:0]    current_qos;
    bit          uplink_present;
    bit          single_down_present;
    bit          code_present;
    qga_status_t status;
  } qga_result_t;

  logic [CFG_W-1:0]  prio_tbl;
  logic [MASK_W-1:0] imm_mask, up_mask, down_mask;

  bit                slot_used [DEVICE_SLOTS];
  logic [ADDR_W-1:0] slot_addr [DEVICE_SLOTS];
  logic [QOS_W-1:0]  slot_cur  [DEVICE_SLOTS];
  int                slot_len  [DEVICE_SLOTS];
  logic [QOS_W-1:0]  group_mem [DEVICE_SLOTS][GROUP_DEPTH];

  qga_result_t result_q[$];

  function automatic bit valid_code(logic [QOS_W-1:0] c);
    return c < QOS_BUTT;
  endfunction

  function automatic logic [3:0] prio_of(logic [QOS_W-1:0] c);
    return valid_code(c) ? prio_tbl[4*c +: 4] : 4'd0;
  endfunction

  function automatic bit mask_bit(logic [MASK_W-1:0] m, logic [QOS_W-1:0] c);
    return valid_code(c) ? m[c] : 1'b0;
  endfunction

  function automatic int lookup_slot(logic [ADDR_W-1:0] a);
    for (int i = 0; i < DEVICE_SLOTS; i++)
      if (slot_used[i] && slot_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic int claim_slot(logic [ADDR_W-1:0] a);
    for (int i = 0; i < DEVICE_SLOTS; i++)
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_addr[i] = a;
        slot_cur[i]  = '0;
        slot_len[i]  = 0;
        return i;
      end
    return -1;
  endfunction

  function automatic bit list_holds(int s, logic [QOS_W-1:0] c);
    for (int i = 0; i < slot_len[s]; i++)
      if (group_mem[s][i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void remove_first(int s, logic [QOS_W-1:0] c);
    for (int i = 0; i < slot_len[s]; i++)
      if (group_mem[s][i] == c) begin
        for (int j = i + 1; j < slot_len[s]; j++) group_mem[s][j-1] = group_mem[s][j];
        slot_len[s]--;
        return;
      end
  endfunction

  function automatic logic [QOS_W-1:0] next_qos(int s);
    logic [3:0]       best;
    logic [QOS_W-1:0] pick;
    best = '0;
    pick = '0;
    for (int i = 0; i < slot_len[s]; i++)
      if (prio_of(group_mem[s][i]) > best) begin
        best = prio_of(group_mem[s][i]);
        pick = group_mem[s][i];
      end
    return pick;
  endfunction

  function automatic bit any_uplink(int s);
    for (int i = 0; i < slot_len[s]; i++)
      if (mask_bit(up_mask, group_mem[s][i])) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit any_single_down(int s);
    for (int i = 0; i < slot_len[s]; i++)
      if (!mask_bit(up_mask, group_mem[s][i]) && mask_bit(down_mask, group_mem[s][i]))
        return 1'b1;
    return 1'b0;
  endfunction

  // A code goes only when no entry of lower priority is left beside it.
  function automatic void drop_if_alone(int s, logic [QOS_W-1:0] c);
    for (int i = 0; i < slot_len[s]; i++)
      if (prio_of(group_mem[s][i]) < prio_of(c)) return;
    remove_first(s, c);
  endfunction

  function automatic qga_status_t delete_code(int s, logic [QOS_W-1:0] q, output bit chg,
                                              output bit stop, output bit now);
    logic [QOS_W-1:0] cos, nos;
    chg = 0; stop = 0; now = 0;
    if (!valid_code(q)) return ST_INVALID;
    if (s < 0) return ST_NO_SLOT;
    if (slot_len[s] == 0) return ST_LIST_EMPTY;
    remove_first(s, q);
    if (list_holds(s, QOS_4)) drop_if_alone(s, QOS_4);
    if (list_holds(s, QOS_8)) drop_if_alone(s, QOS_8);
    if (q != QOS_10 && q != QOS_3 && list_holds(s, QOS_10)) drop_if_alone(s, QOS_10);
    cos = slot_cur[s];
    if (cos == QOS_3 && any_uplink(s)) nos = QOS_3;
    else if (cos == QOS_2 && any_single_down(s)) nos = QOS_2;
    else nos = next_qos(s);
    if (nos == 0) begin
      stop = 1;
      now  = mask_bit(imm_mask, cos);
    end
    if (prio_of(cos) > prio_of(nos) && nos != 0) begin
      slot_cur[s] = nos;
      chg = 1;
    end else if (cos == QOS_10) begin
      slot_cur[s] = nos;
    end
    return ST_OK;
  endfunction

  function automatic qga_status_t add_code(int s, logic [QOS_W-1:0] q, output bit chg);
    logic [QOS_W-1:0] cos, nos;
    chg = 0;
    if (slot_len[s] >= GROUP_DEPTH) return ST_LIST_FULL;
    group_mem[s][slot_len[s]] = q;
    slot_len[s]++;
    nos = next_qos(s);
    cos = slot_cur[s];
    if (cos == QOS_2 && nos == QOS_4 && !list_holds(s, QOS_2)) begin
      slot_cur[s] = nos; chg = 1;
    end else if (prio_of(cos) < prio_of(nos)) begin
      slot_cur[s] = nos; chg = 1;
    end else if (prio_of(cos) == prio_of(nos) &&
                 ((cos == QOS_4 && nos == QOS_8) || (cos == QOS_8 && nos == QOS_4))) begin
      chg = 1;
    end else if (cos == QOS_3 && q != QOS_3 && !list_holds(s, QOS_3)) begin
      slot_cur[s] = nos; chg = 1;
    end
    return ST_OK;
  endfunction

  function automatic qga_result_t run_command(logic [2:0] cmd, logic [ADDR_W-1:0] dev,
                                              logic [QOS_W-1:0] q, logic [ADDR_W-1:0] peer);
    qga_result_t r;
    int s, p, n;
    bit a, b, c;
    r = '{status: ST_OK, default: '0};
    s = lookup_slot(dev);
    case (cmd)
      CMD_ADD: begin
        if (!valid_code(q)) r.status = ST_INVALID;
        else begin
          if (s < 0) s = claim_slot(dev);
          r.status = (s < 0) ? ST_TABLE_FULL : add_code(s, q, r.changed);
        end
      end
      CMD_DELETE: r.status = delete_code(s, q, r.changed, r.stop_stream, r.stop_now);
      CMD_CLEAR: begin
        if (s < 0) r.status = ST_NO_SLOT;
        else begin
          slot_cur[s] = '0;
          slot_len[s] = 0;
        end
      end
      CMD_CLEAR_FAILED: begin
        void'(delete_code(s, q, a, b, c));
        if (s < 0) r.status = ST_NO_SLOT;
        else begin
          if (slot_len[s] == 0) slot_cur[s] = '0;
          r.status = valid_code(q) ? ST_OK : ST_INVALID;
        end
      end
      CMD_SET: begin
        if (s < 0) r.status = ST_NO_SLOT;
        else if (!valid_code(q)) r.status = ST_INVALID;
        else slot_cur[s] = q;
      end
      CMD_SYNC: begin
        p = lookup_slot(peer);
        if (p < 0) r.status = ST_NO_SLOT;
        else if (slot_len[p] == 0) r.status = ST_LIST_EMPTY;
        else if (s >= 0 && slot_len[s] + slot_len[p] > GROUP_DEPTH) r.status = ST_LIST_FULL;
        else begin
          if (s < 0) s = claim_slot(dev);
          if (s < 0) r.status = ST_TABLE_FULL;
          else begin
            // Length is latched first, so a sync with itself copies the old list.
            n = slot_len[p];
            for (int i = 0; i < n; i++) group_mem[s][slot_len[s] + i] = group_mem[p][n-1-i];
            slot_len[s] += n;
            slot_cur[s] = slot_cur[p];
          end
        end
      end
      default: if (s < 0) r.status = ST_NO_SLOT;
    endcase
    if (s >= 0) begin
      r.current_qos         = slot_cur[s];
      r.uplink_present      = any_uplink(s);
      r.single_down_present = any_single_down(s);
      r.code_present        = list_holds(s, q);
    end
    return r;
  endfunction

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    qga_result_t r;
    if (rst) begin
      prio_tbl  = PRIORITY_RESET;
      imm_mask  = IMM_RESET;
      up_mask   = UP_RESET;
      down_mask = DOWN_RESET;
      for (int i = 0; i < DEVICE_SLOTS; i++) slot_used[i] = 1'b0;
      result_q.delete();
      errors   = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (qga_reg_t'(cfg_index))
          REG_PRIORITY: prio_tbl  = cfg_data;
          REG_IMM_STOP: imm_mask  = cfg_data[MASK_W-1:0];
          REG_UPLINK:   up_mask   = cfg_data[MASK_W-1:0];
          REG_DOWNLINK: down_mask = cfg_data[MASK_W-1:0];
        endcase
      end
      if (s_tvalid && s_tready)
        result_q.push_back(run_command(s_tdata[2:0], s_tdata[50:3], s_tdata[54:51],
                                       s_tdata[102:55]));
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          r = result_q.pop_front();
          compare_field("changed", r.changed, m_tdata[0]);
          compare_field("stop_stream", r.stop_stream, m_tdata[1]);
          compare_field("stop_now", r.stop_now, m_tdata[2]);
          compare_field("current_qos", r.current_qos, m_tdata[6:3]);
          compare_field("uplink_present", r.uplink_present, m_tdata[7]);
          compare_field("single_down_present", r.single_down_present, m_tdata[8]);
          compare_field("code_present", r.code_present, m_tdata[9]);
          compare_field("status", r.status, m_tdata[12:10]);
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

// ----- bench/tb_stream_qos_group_arbiter.sv -----
// Testbench top for the stream QoS group arbiter: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_stream_qos_group_arbiter;
  import qga_pkg::*;

  localparam logic [2:0] CMD_QUERY_ALIAS = 3'd7;
  localparam int         POOL_SIZE       = 10;
  localparam int         CYCLE_LIMIT     = 1000000;

  logic              clk;
  logic              rst;
  logic              s_tvalid, s_tready;
  logic [103:0]      s_tdata;
  logic              m_tvalid, m_tready;
  logic [15:0]       m_tdata;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  int                errors, pending;
  int                cycles;
  int                stall_mode;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  stream_qos_group_arbiter dut (.*);

  qga_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: alternates between free running, short stalls and long stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 19) == 0);
    endcase
  end

  function automatic logic [ADDR_W-1:0] random_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    return ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_SIZE-1)]
                                        : random_addr();
  endfunction

  task automatic send_command(logic [2:0] cmd, logic [ADDR_W-1:0] dev,
                              logic [QOS_W-1:0] q, logic [ADDR_W-1:0] peer);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, peer, q, dev, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(qga_reg_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Registers change only once every expected word is back and the block has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [2:0]       cmd;
    logic [QOS_W-1:0] q;
    int               w;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      cmd = (w < 40) ? CMD_ADD : (w < 68) ? CMD_DELETE : (w < 72) ? CMD_CLEAR :
            (w < 78) ? CMD_CLEAR_FAILED : (w < 84) ? CMD_SET : (w < 92) ? CMD_SYNC :
            (w < 97) ? CMD_QUERY : CMD_QUERY_ALIAS;
      q = ($urandom_range(0, 9) == 0) ? QOS_W'($urandom_range(11, 15))
                                      : QOS_W'($urandom_range(0, 10));
      send_command(cmd, pick_addr(), q, pick_addr());
    end
    drain();
  endtask

  initial begin
    logic [ADDR_W-1:0] a0, a1;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0; cycles = 0; stall_mode = 0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = random_addr();
    a0 = addr_pool[0];
    a1 = addr_pool[1];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every command and the special cases.
    send_command(CMD_DELETE, a0, QOS_2, a1);       // no slot
    send_command(CMD_ADD, a0, 4'd15, a1);          // invalid code
    send_command(CMD_ADD, a0, 4'd0, a1);
    send_command(CMD_ADD, a0, QOS_2, a1);
    send_command(CMD_ADD, a0, QOS_4, a1);          // 2 stays, 4 ranks lower
    send_command(CMD_ADD, a0, QOS_8, a1);
    send_command(CMD_ADD, a0, QOS_10, a1);
    send_command(CMD_ADD, a0, QOS_3, a1);
    send_command(CMD_DELETE, a0, QOS_3, a1);
    send_command(CMD_DELETE, a0, QOS_10, a1);
    send_command(CMD_DELETE, a0, 4'd12, a1);
    send_command(CMD_SET, a0, 4'd11, a1);
    send_command(CMD_SET, a1, QOS_3, a0);          // no slot for set
    send_command(CMD_SET, a0, QOS_3, a1);
    send_command(CMD_SYNC, a1, QOS_2, 48'h123456789abc);  // unknown peer
    send_command(CMD_SYNC, a1, QOS_4, a0);
    send_command(CMD_SYNC, a1, QOS_4, a1);         // sync with itself
    send_command(CMD_CLEAR_FAILED, a1, 4'd13, a0);
    send_command(CMD_CLEAR_FAILED, a1, QOS_4, a0);
    send_command(CMD_CLEAR, a0, QOS_2, a1);
    send_command(CMD_DELETE, a0, QOS_2, a1);       // empty list
    send_command(CMD_SYNC, a1, QOS_2, a0);         // empty peer list
    send_command(CMD_QUERY, a1, QOS_8, a0);
    send_command(CMD_QUERY_ALIAS, a0, 4'd10, a1);
    drain();

    random_phase(110);
    write_reg(REG_PRIORITY, CFG_W'({$urandom, $urandom}));
    write_reg(REG_IMM_STOP, CFG_W'($urandom));
    write_reg(REG_UPLINK, CFG_W'($urandom));
    write_reg(REG_DOWNLINK, CFG_W'($urandom));
    random_phase(110);
    write_reg(REG_PRIORITY, '1);
    write_reg(REG_IMM_STOP, '1);
    write_reg(REG_UPLINK, '1);
    write_reg(REG_DOWNLINK, '1);
    random_phase(100);
    write_reg(REG_PRIORITY, '0);
    write_reg(REG_IMM_STOP, '0);
    write_reg(REG_UPLINK, '0);
    write_reg(REG_DOWNLINK, '0);
    random_phase(100);
    write_reg(REG_PRIORITY, CFG_W'({$urandom, $urandom}));
    write_reg(REG_IMM_STOP, CFG_W'($urandom));
    write_reg(REG_UPLINK, CFG_W'($urandom));
    write_reg(REG_DOWNLINK, CFG_W'($urandom));
    random_phase(110);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
